// File: rtl/htpc_pkg.sv
// ----------------------------------------------------------------------------
// htpc_pkg
// Shared types and constants for the hashed test-pattern checker.
// ----------------------------------------------------------------------------
package htpc_pkg;

  // Offset width taken into the pattern mix (the source offset is masked to it)
  localparam int unsigned OFFSET_BITS = 40;
  localparam logic [63:0] OFFSET_MASK =
    (OFFSET_BITS >= 64) ? {64{1'b1}} : ((64'd1 << OFFSET_BITS) - 64'd1);

  // Field widths
  localparam int unsigned OFS_W       = 40;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // Entries in the queue between front and back end
  localparam int unsigned Q_DEPTH     = 2;

  // Mixer constants
  localparam logic [63:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FINAL_MUL  = 64'hff51afd7ed558ccd;
  localparam logic [31:0] GOLDEN_LO  = GOLDEN_MUL[31:0];
  localparam logic [31:0] GOLDEN_HI  = GOLDEN_MUL[63:32];
  localparam logic [31:0] FINAL_LO   = FINAL_MUL[31:0];
  localparam logic [8:0]  FINAL_MH   = FINAL_MUL[40:32];

  // Bits of the first xor-shift result that the expected byte depends on
  localparam int unsigned MIX_W = 41;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_RANK      = 3'd0,
    CFG_DESTINATION_RANK = 3'd1,
    CFG_GPU_INDEX        = 3'd2,
    CFG_ITERATION        = 3'd3
  } cfg_idx_e;

  // Input transaction
  typedef struct packed {
    logic             op;
    logic [7:0]       data_byte;
    logic [OFS_W-1:0] src_ofs;
    logic [OFS_W-1:0] dst_ofs;
    logic             last;
  } htpc_in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]       expected_byte;
    logic             mismatch;
    logic             run_failed;
    logic [OFS_W-1:0] first_bad_offset;
    logic             run_end;
  } htpc_out_t;

  // Derived configuration seen by the back end
  typedef struct packed {
    logic [63:0] iter_p1;   // iteration + 1
    logic [63:0] rank_mix;  // xor of the shifted rank and gpu terms
  } htpc_cfg_t;

  // Classified queue entry
  typedef struct packed {
    logic             is_check;
    logic             is_last;
    logic [7:0]       data_byte;
    logic [63:0]      offset;   // masked source offset
    logic [OFS_W-1:0] dst_ofs;
  } htpc_qent_t;

endpackage

// File: rtl/htpc_cfg.sv
// ----------------------------------------------------------------------------
// htpc_cfg
// Configuration registers; presents iteration + 1 and the combined rank term.
// ----------------------------------------------------------------------------
module htpc_cfg import htpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output htpc_cfg_t             cfg_o
);

  logic [14:0] src_rank_q;
  logic [15:0] dst_rank_q;
  logic [14:0] gpu_idx_q;
  logic [63:0] iter_p1_q;

  logic [15:0] src_term;
  logic [31:0] dst_term;
  logic [15:0] gpu_term;

  // Register writes; iteration is stored pre-incremented
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rank_q <= '0;
      dst_rank_q <= '0;
      gpu_idx_q  <= '0;
      iter_p1_q  <= 64'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_RANK:      src_rank_q <= cfg_wdata_i[14:0];
        CFG_DESTINATION_RANK: dst_rank_q <= cfg_wdata_i[15:0];
        CFG_GPU_INDEX:        gpu_idx_q  <= cfg_wdata_i[14:0];
        CFG_ITERATION:        iter_p1_q  <= cfg_wdata_i + 64'd1;
        default: ;
      endcase
    end
  end

  // Rank terms: (rank + 1) placed at its bit position, dst rank sign-extended
  assign src_term = {1'b0, src_rank_q} + 16'd1;
  assign gpu_term = {1'b0, gpu_idx_q} + 16'd1;
  assign dst_term = {{16{dst_rank_q[15]}}, dst_rank_q} + 32'd1;

  assign cfg_o.iter_p1  = iter_p1_q;
  assign cfg_o.rank_mix = {src_term, 48'd0}
                        ^ {dst_term, 32'd0}
                        ^ {32'd0, gpu_term, 16'd0};

endmodule

// File: rtl/htpc_front.sv
// ----------------------------------------------------------------------------
// htpc_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module htpc_front import htpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  htpc_in_t   in_data_i,
  output logic       q_valid_o,
  output htpc_qent_t q_entry_o,
  input  logic       q_pop_i
);

  htpc_qent_t    mem_q [Q_DEPTH];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          push;
  logic          pop;
  htpc_qent_t    ent;

  // Classification: check vs generate, end of run, masked pattern offset
  always_comb begin
    ent            = '0;
    ent.is_check   = in_data_i.op;
    ent.is_last    = in_data_i.last;
    ent.data_byte  = in_data_i.data_byte;
    ent.offset     = {{(64-OFS_W){1'b0}}, in_data_i.src_ofs} & OFFSET_MASK;
    ent.dst_ofs    = in_data_i.dst_ofs;
  end

  assign in_stall_o = (count_q == 2'(Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_entry_o  = mem_q[rd_ptr_q];

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= ent;
  end

endmodule

// File: rtl/htpc_back.sv
// ----------------------------------------------------------------------------
// htpc_back
// Pattern mixing pipeline, compare, sticky run status and result register.
// ----------------------------------------------------------------------------
module htpc_back import htpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  htpc_cfg_t  cfg_i,
  input  logic       q_valid_i,
  input  htpc_qent_t q_entry_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output htpc_out_t  out_data_o
);

  // Control carried along the pipe
  typedef struct packed {
    logic             is_check;
    logic             is_last;
    logic [7:0]       data_byte;
    logic [OFS_W-1:0] dst_ofs;
  } ctl_t;

  logic en;

  logic        s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  ctl_t        s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [63:0] s1_offset_q;
  logic [63:0] s1_p00_q;
  logic [31:0] s1_p01_q, s1_p10_q;
  logic [MIX_W-1:0] s2_y_q;
  logic [MIX_W-1:0] s3_q00_q;
  logic [8:0]  s3_q01_q, s3_q10_q;
  htpc_out_t   out_q;

  logic        failed_q;
  logic [OFS_W-1:0] fail_ofs_q;

  logic [63:0] p00_d;
  logic [31:0] p01_d, p10_d;
  logic [63:0] prod;
  logic [63:0] x;
  logic [MIX_W-1:0] y_d;
  logic [MIX_W-1:0] q00_d;
  logic [8:0]  q01_d, q10_d;
  logic [8:0]  cross_sum;
  logic [MIX_W-1:0] z;
  logic [7:0]  exp_byte;
  logic        bad;
  logic        failed_d;
  logic [OFS_W-1:0] fail_ofs_d;
  htpc_out_t   res;

  // Whole back end holds while a result waits on a stalled consumer
  assign en      = !(out_valid_q && out_stall_i);
  assign q_pop_o = q_valid_i && en;

  // S1: partial products of (iteration + 1) * golden constant
  assign p00_d = 64'(cfg_i.iter_p1[31:0]) * 64'(GOLDEN_LO);
  assign p01_d = cfg_i.iter_p1[31:0] * GOLDEN_HI;
  assign p10_d = cfg_i.iter_p1[63:32] * GOLDEN_LO;

  // S2: finish the product, fold in offset and ranks, first xor-shift
  assign prod = s1_p00_q + {s1_p01_q + s1_p10_q, 32'd0};
  assign x    = s1_offset_q ^ prod ^ cfg_i.rank_mix;
  assign y_d  = x[MIX_W-1:0] ^ {{(MIX_W-31){1'b0}}, x[63:33]};

  // S3: low bits of y * final constant, split into partial products
  assign q00_d = MIX_W'(s2_y_q[31:0]) * MIX_W'(FINAL_LO);
  assign q01_d = s2_y_q[8:0] * FINAL_MH;
  assign q10_d = s2_y_q[40:32] * FINAL_LO[8:0];

  // S4: sum, second xor-shift, compare and run status
  assign cross_sum = s3_q01_q + s3_q10_q;
  assign z         = s3_q00_q + {cross_sum, 32'd0};
  assign exp_byte  = z[7:0] ^ z[40:33];
  assign bad       = s3_ctl_q.is_check && (s3_ctl_q.data_byte != exp_byte);
  assign failed_d   = failed_q || bad;
  assign fail_ofs_d = (!failed_q && bad) ? s3_ctl_q.dst_ofs : fail_ofs_q;

  always_comb begin
    res                  = '0;
    res.expected_byte    = exp_byte;
    res.mismatch         = bad;
    res.run_failed       = failed_d;
    res.first_bad_offset = fail_ofs_d;
    res.run_end          = s3_ctl_q.is_last;
  end

  // Valid flags and sticky status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      failed_q    <= 1'b0;
      fail_ofs_q  <= '0;
    end else if (en) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      if (s3_valid_q) begin
        if (s3_ctl_q.is_last) begin
          failed_q   <= 1'b0;
          fail_ofs_q <= '0;
        end else begin
          failed_q   <= failed_d;
          fail_ofs_q <= fail_ofs_d;
        end
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctl_q.is_check   <= q_entry_i.is_check;
      s1_ctl_q.is_last    <= q_entry_i.is_last;
      s1_ctl_q.data_byte  <= q_entry_i.data_byte;
      s1_ctl_q.dst_ofs    <= q_entry_i.dst_ofs;
      s1_offset_q <= q_entry_i.offset;
      s1_p00_q    <= p00_d;
      s1_p01_q    <= p01_d;
      s1_p10_q    <= p10_d;
      s2_ctl_q    <= s1_ctl_q;
      s2_y_q      <= y_d;
      s3_ctl_q    <= s2_ctl_q;
      s3_q00_q    <= q00_d;
      s3_q01_q    <= q01_d;
      s3_q10_q    <= q10_d;
      out_q       <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/hashed_test_pattern_checker_core.sv
// ----------------------------------------------------------------------------
// hashed_test_pattern_checker_core: an entry passes the queue (written at the
// accepting edge), golden product, first mix, final product, result register.
// One transaction per cycle while no result is stalled; both multiplies are
// split over pipeline stages. A stalled result holds the whole back end.
// Reset: run status clear, queue and pipeline empty, iteration + 1 reads 1.
// ----------------------------------------------------------------------------
module hashed_test_pattern_checker_core import htpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  htpc_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output htpc_out_t             out_data_o
);

  htpc_cfg_t  cfg;
  logic       q_valid;
  htpc_qent_t q_entry;
  logic       q_pop;

  // Configuration registers
  htpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Front end: accept, classify, queue
  htpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  // Back end: pattern mix, compare, result
  htpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
